// ===== rtl/core/xorshift64star_byte_generator_defines.svh =====
// Assertion macros shared by the generator RTL.
`ifndef XORSHIFT64STAR_BYTE_GENERATOR_DEFINES_SVH
`define XORSHIFT64STAR_BYTE_GENERATOR_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define XSBG_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("xsbg assertion failed");

// Next-cycle implication, checked out of reset.
`define XSBG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("xsbg assertion failed");

`endif

// ===== rtl/core/xsbg_pkg.sv =====
// Types and constants of the xorshift64* byte generator.
package xsbg_pkg;

    typedef logic [63:0] t_word;
    typedef logic [31:0] t_half;

    localparam t_word SEED_XOR  = 64'h9E37_79B9_7F4A_7C15;
    localparam t_word SEED_MUL  = 64'hBF58_476D_1CE4_E5B9;
    localparam t_word SEED_ZERO = 64'h9E37_79B9_5A4A_7C15;
    localparam t_word OUT_MUL   = 64'h2545_F491_4F6C_DD1D;

    localparam int unsigned SHIFT_A    = 12;
    localparam int unsigned SHIFT_B    = 25;
    localparam int unsigned SHIFT_C    = 27;
    localparam int unsigned SHIFT_FOLD = 21;

    localparam logic OP_SEED = 1'b0;
    localparam logic OP_READ = 1'b1;

endpackage

// ===== rtl/core/xsbg_mul.sv =====
// Shared 32x32 multiplier with registered 64-bit product.
module xsbg_mul
    import xsbg_pkg::*;
(
    input  logic  i_clk,
    input  t_half i_a,
    input  t_half i_b,
    output t_word o_p
);

    t_word r_p;

    always_ff @(posedge i_clk) begin
        r_p <= t_word'(i_a) * t_word'(i_b);
    end

    assign o_p = r_p;

endmodule

// ===== rtl/core/xorshift64star_byte_generator.sv =====
// Seed: multiply in 4 partial steps (S_MUL0..S_MUL3), then fold. Read: S_SHIFT and the
// multiply precede the first byte, then 1 byte per cycle while i_ready is high; each further
// 8-byte word repeats S_SHIFT and the multiply first. One request at a time; the block
// uses the single 32x32 multiplier, taking three partial products per word.
// Reset (synchronous, active low) returns to idle and clears the generator state to zero.
module xorshift64star_byte_generator
    import xsbg_pkg::*;
#(
    parameter int unsigned MAX_READ_BYTES = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic        i_operation,
    input  logic [31:0] i_tick_value,
    input  logic [6:0]  i_byte_count,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_random_byte,
    output logic        o_last_byte
);

`include "xorshift64star_byte_generator_defines.svh"

    localparam int unsigned CW = $clog2(MAX_READ_BYTES + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_MUL0,
        S_MUL1,
        S_MUL2,
        S_MUL3,
        S_FOLD,
        S_EMIT
    } t_fsm;

    t_fsm          r_fsm,    n_fsm;
    t_word         r_state,  n_state;
    t_word         r_opa,    n_opa;
    t_word         r_acc,    n_acc;
    logic          r_seed,   n_seed;
    logic [CW-1:0] r_remain, n_remain;
    logic [2:0]    r_bidx,   n_bidx;

    t_half mul_a;
    t_half mul_b;
    t_word mul_p;
    t_word cmul;
    t_word xs1;
    t_word xs2;
    t_word xs3;
    t_word fold;
    t_word tick_ext;
    logic [CW-1:0] count_sat;

    xsbg_mul u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign cmul = r_seed ? SEED_MUL : OUT_MUL;

    // Partial products: lo*lo, lo*hi, hi*lo; the hi*hi term falls off mod 2^64.
    always_comb begin
        mul_a = r_opa[31:0];
        mul_b = cmul[31:0];
        unique case (r_fsm)
            S_MUL1:  mul_b = cmul[63:32];
            S_MUL2:  mul_a = r_opa[63:32];
            default: ;
        endcase
    end

    assign xs1  = r_state ^ (r_state >> SHIFT_A);
    assign xs2  = xs1 ^ (xs1 << SHIFT_B);
    assign xs3  = xs2 ^ (xs2 >> SHIFT_C);
    assign fold = r_acc ^ (r_acc >> SHIFT_FOLD);

    assign tick_ext  = {{32{i_tick_value[31]}}, i_tick_value};
    assign count_sat = (i_byte_count > 7'(MAX_READ_BYTES)) ? CW'(MAX_READ_BYTES)
                                                           : i_byte_count[CW-1:0];

    always_comb begin
        n_fsm    = r_fsm;
        n_state  = r_state;
        n_opa    = r_opa;
        n_acc    = r_acc;
        n_seed   = r_seed;
        n_remain = r_remain;
        n_bidx   = r_bidx;
        unique case (r_fsm)
            S_IDLE: begin
                if (i_valid) begin
                    if (i_operation == OP_SEED) begin
                        n_seed = 1'b1;
                        n_opa  = tick_ext ^ SEED_XOR;
                        n_fsm  = S_MUL0;
                    end else begin
                        n_seed   = 1'b0;
                        n_remain = count_sat;
                        n_bidx   = 3'd0;
                        // drop zero-length reads
                        if (count_sat != '0) begin
                            n_fsm = S_SHIFT;
                        end
                    end
                end
            end
            S_SHIFT: begin
                n_state = xs3;
                n_opa   = xs3;
                n_fsm   = S_MUL0;
            end
            S_MUL0: n_fsm = S_MUL1;
            S_MUL1: begin
                n_acc = mul_p;
                n_fsm = S_MUL2;
            end
            S_MUL2: begin
                n_acc[63:32] = r_acc[63:32] + mul_p[31:0];
                n_fsm        = S_MUL3;
            end
            S_MUL3: begin
                n_acc[63:32] = r_acc[63:32] + mul_p[31:0];
                n_fsm        = r_seed ? S_FOLD : S_EMIT;
            end
            S_FOLD: begin
                n_state = (fold == '0) ? SEED_ZERO : fold;
                n_fsm   = S_IDLE;
            end
            S_EMIT: begin
                if (i_ready) begin
                    n_acc    = r_acc >> 8;
                    n_remain = r_remain - CW'(1);
                    n_bidx   = r_bidx + 3'd1;
                    if (r_remain == CW'(1)) begin
                        n_fsm = S_IDLE;
                    end else if (r_bidx == 3'd7) begin
                        // advance the generator for the next word
                        n_fsm = S_SHIFT;
                    end
                end
            end
            default: n_fsm = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm    <= S_IDLE;
            r_state  <= '0;
            r_remain <= '0;
            r_bidx   <= '0;
            r_seed   <= 1'b0;
        end else begin
            r_fsm    <= n_fsm;
            r_state  <= n_state;
            r_remain <= n_remain;
            r_bidx   <= n_bidx;
            r_seed   <= n_seed;
        end
        r_opa <= n_opa;
        r_acc <= n_acc;
    end

    assign o_ready       = (r_fsm == S_IDLE);
    assign o_valid       = (r_fsm == S_EMIT);
    assign o_random_byte = r_acc[7:0];
    assign o_last_byte   = (r_remain == CW'(1));

    `XSBG_ASSERT_NOW(a_busy_while_emit, i_clk, i_rst_n, o_valid, !o_ready)
    `XSBG_ASSERT_NOW(a_emit_has_bytes, i_clk, i_rst_n, o_valid, r_remain != '0)
    `XSBG_ASSERT_NEXT(a_last_ends_read, i_clk, i_rst_n,
        o_valid && i_ready && o_last_byte, !o_valid && o_ready)
    `XSBG_ASSERT_NEXT(a_seed_nonzero, i_clk, i_rst_n, r_fsm == S_FOLD, r_state != '0)

endmodule
